// ----- sv/pee_pkg.sv -----
// ----------------------------------------------------------------------------
// pee_pkg
// shared types and constants of the expression evaluator
// ----------------------------------------------------------------------------
package pee_pkg;

  localparam int VW = 64;

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_MOD = 3'd4;
  localparam logic [2:0] CMD_POW = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NEXP = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  localparam logic [1:0] TOP_NONE = 2'd0;
  localparam logic [1:0] TOP_MUL  = 2'd1;
  localparam logic [1:0] TOP_DIV  = 2'd2;
  localparam logic [1:0] TOP_MOD  = 2'd3;

  // classified operation
  localparam logic [1:0] K_FIRST = 2'd0;
  localparam logic [1:0] K_POW   = 2'd1;
  localparam logic [1:0] K_MD    = 2'd2;
  localparam logic [1:0] K_AS    = 2'd3;

  typedef struct packed {
    logic [VW-1:0] opd;
    logic [1:0]    kind;
    logic [1:0]    mdop;
    logic          sub;
    logic          last;
  } op_t;

  localparam int QD = 2;

endpackage

// ----- sv/pee_front.sv -----
// ----------------------------------------------------------------------------
// pee_front
// accepts operands, classifies the operator and queues the transaction
// ----------------------------------------------------------------------------
module pee_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [63:0]      in_tdata,
  input  logic [2:0]       in_tuser,
  input  logic             in_tlast,
  output logic             q_valid,
  input  logic             q_ready,
  output pee_pkg::op_t     q_data
);

  pee_pkg::op_t mem_r [pee_pkg::QD];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         first_r;
  pee_pkg::op_t cls;
  logic         push, pop;

  always_comb begin
    cls.opd  = in_tdata[pee_pkg::VW-1:0];
    cls.last = in_tlast;
    cls.mdop = pee_pkg::TOP_NONE;
    cls.sub  = 1'b0;
    if (first_r) begin
      cls.kind = pee_pkg::K_FIRST;
    end else begin
      case (in_tuser)
        pee_pkg::CMD_POW: cls.kind = pee_pkg::K_POW;
        pee_pkg::CMD_MUL: begin
          cls.kind = pee_pkg::K_MD;
          cls.mdop = pee_pkg::TOP_MUL;
        end
        pee_pkg::CMD_DIV: begin
          cls.kind = pee_pkg::K_MD;
          cls.mdop = pee_pkg::TOP_DIV;
        end
        pee_pkg::CMD_MOD: begin
          cls.kind = pee_pkg::K_MD;
          cls.mdop = pee_pkg::TOP_MOD;
        end
        pee_pkg::CMD_ADD: cls.kind = pee_pkg::K_AS;
        default: begin
          cls.kind = pee_pkg::K_AS;
          cls.sub  = 1'b1;
        end
      endcase
    end
  end

  assign in_tready = (cnt_r != 2'(pee_pkg::QD));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_data    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cls;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
      first_r <= 1'b1;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
        first_r <= in_tlast;
      end
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(pee_pkg::QD)) else $error("queue overfill");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'(pee_pkg::QD)) |-> !in_tready) else $error("ready while full");
  a_first_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push && in_tlast) |=> first_r) else $error("frame start lost");

endmodule

// ----- sv/pee_alu.sv -----
// ----------------------------------------------------------------------------
// pee_alu
// shared multicycle unit: multiply, square-and-multiply power, modulo, divide
// ----------------------------------------------------------------------------
module pee_alu (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [1:0]                op,
  input  logic [pee_pkg::VW-1:0]    a,
  input  logic [pee_pkg::VW-1:0]    b,
  output logic                      done,
  output logic [pee_pkg::VW-1:0]    res
);

  localparam int VW = pee_pkg::VW;
  localparam int CW = $clog2(VW);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_PCHK = 3'd2;
  localparam logic [2:0] S_PRM  = 3'd3;
  localparam logic [2:0] S_PSQ  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;

  // op: 0 mul, 1 pow, 2 div, 3 mod
  localparam logic [1:0] A_MUL = 2'd0;
  localparam logic [1:0] A_POW = 2'd1;
  localparam logic [1:0] A_DIV = 2'd2;

  logic [2:0]    st_r;
  logic [CW-1:0] cnt_r;
  logic [VW-1:0] acc_r, mc_r, mp_r, x_r, e_r, r_r, q_r, rm_r, d_r;
  logic          na_r, nb_r, mod_r;
  logic          done_r;
  logic [VW-1:0] res_r;
  logic [VW:0]   trial;
  logic [VW-1:0] rsh, prod, rem, quo;
  logic          last_step, fin;

  assign done      = done_r;
  assign res       = res_r;
  assign rsh       = {rm_r[VW-2:0], q_r[VW-1]};
  assign trial     = {1'b0, rsh} - {1'b0, d_r};
  assign rem       = trial[VW] ? rsh : trial[VW-1:0];
  assign quo       = {q_r[VW-2:0], ~trial[VW]};
  assign prod      = mp_r[0] ? acc_r + mc_r : acc_r;
  assign last_step = (cnt_r == CW'(VW - 1));
  assign fin       = ((st_r == S_MUL || st_r == S_DIV) && last_step) ||
                     (st_r == S_PCHK && e_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= fin;
      case (st_r)
        S_IDLE: begin
          if (start) begin
            cnt_r <= '0;
            acc_r <= '0;
            case (op)
              A_MUL: begin
                st_r <= S_MUL;
                mc_r <= a;
                mp_r <= b;
              end
              A_POW: begin
                st_r <= S_PCHK;
                x_r <= a;
                e_r <= b;
                r_r <= {{(VW-1){1'b0}}, 1'b1};
              end
              default: begin
                st_r <= S_DIV;
                na_r <= a[VW-1];
                nb_r <= b[VW-1];
                mod_r <= (op != A_DIV);
                q_r <= a[VW-1] ? (~a + VW'(1)) : a;
                d_r <= b[VW-1] ? (~b + VW'(1)) : b;
                rm_r <= '0;
              end
            endcase
          end
        end
        S_MUL: begin
          acc_r <= prod;
          mc_r <= mc_r << 1;
          mp_r <= mp_r >> 1;
          cnt_r <= cnt_r + CW'(1);
          if (last_step) begin
            st_r <= S_IDLE;
            res_r <= prod;
          end
        end
        S_PCHK: begin
          // one exponent bit: optional r*=x, then x*=x while bits remain
          cnt_r <= '0;
          acc_r <= '0;
          if (e_r == '0) begin
            st_r <= S_IDLE;
            res_r <= r_r;
          end else if (e_r[0]) begin
            mc_r <= r_r;
            mp_r <= x_r;
            st_r <= S_PRM;
          end else begin
            mc_r <= x_r;
            mp_r <= x_r;
            st_r <= S_PSQ;
          end
        end
        S_PRM: begin
          if (last_step) begin
            r_r <= prod;
            cnt_r <= '0;
            acc_r <= '0;
            mc_r <= x_r;
            mp_r <= x_r;
            if (e_r[VW-1:1] == '0) begin
              e_r <= '0;
              st_r <= S_PCHK;
            end else begin
              st_r <= S_PSQ;
            end
          end else begin
            acc_r <= prod;
            mc_r <= mc_r << 1;
            mp_r <= mp_r >> 1;
            cnt_r <= cnt_r + CW'(1);
          end
        end
        S_PSQ: begin
          if (last_step) begin
            x_r <= prod;
            e_r <= e_r >> 1;
            st_r <= S_PCHK;
          end else begin
            acc_r <= prod;
            mc_r <= mc_r << 1;
            mp_r <= mp_r >> 1;
            cnt_r <= cnt_r + CW'(1);
          end
        end
        S_DIV: begin
          rm_r <= rem;
          q_r <= quo;
          cnt_r <= cnt_r + CW'(1);
          if (last_step) begin
            st_r <= S_IDLE;
            if (mod_r) begin
              res_r <= na_r ? (~rem + VW'(1)) : rem;
            end else begin
              res_r <= (na_r != nb_r) ? (~quo + VW'(1)) : quo;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> st_r == S_IDLE) else $error("done while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done held");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && st_r == S_IDLE) |=> st_r != S_IDLE) else $error("start lost");

endmodule

// ----- sv/pee_back.sv -----
// ----------------------------------------------------------------------------
// pee_back
// precedence state machine: power, term and sum registers and result stage
// ----------------------------------------------------------------------------
module pee_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  pee_pkg::op_t         q_data,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [63:0]          out_tdata,
  output logic [1:0]           out_tuser
);

  localparam int VW = pee_pkg::VW;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POW  = 3'd1;
  localparam logic [2:0] S_CT   = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;
  localparam logic [2:0] S_MD   = 3'd6;

  localparam logic [1:0] A_MUL = 2'd0;
  localparam logic [1:0] A_POW = 2'd1;
  localparam logic [1:0] A_DIV = 2'd2;
  localparam logic [1:0] A_MOD = 2'd3;

  logic [2:0]    st_r;
  pee_pkg::op_t  cur_r;
  logic [VW-1:0] sum_r, term_r, pow_r, ct_r;
  logic          sub_r;
  logic [1:0]    top_r, err_r;
  logic          ov_r;
  logic [VW-1:0] oval_r;
  logic [1:0]    ost_r;
  logic          a_start, a_done;
  logic [1:0]    a_op;
  logic [VW-1:0] a_a, a_b, a_res;
  logic          go_r;
  logic [VW-1:0] sumc;
  logic          emit, issue;

  pee_alu u_alu (
    .clk(clk), .rst_n(rst_n), .start(a_start), .op(a_op), .a(a_a), .b(a_b),
    .done(a_done), .res(a_res)
  );

  assign q_ready    = (st_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = oval_r;
  assign out_tuser  = ost_r;
  assign a_start    = go_r;
  assign sumc       = sub_r ? sum_r - ct_r : sum_r + ct_r;
  assign emit       = (st_r == S_WAIT) && (cur_r.kind != pee_pkg::K_MD) &&
                      (cur_r.kind != pee_pkg::K_AS) && (!ov_r || out_tready);
  assign issue      = (st_r == S_IDLE && q_valid && q_data.kind == pee_pkg::K_POW &&
                       !q_data.opd[VW-1]) ||
                      (st_r == S_CT && top_r != pee_pkg::TOP_NONE &&
                       !(top_r != pee_pkg::TOP_MUL && pow_r == '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
      go_r <= 1'b0;
      sum_r <= '0;
      sub_r <= 1'b0;
      term_r <= '0;
      top_r <= pee_pkg::TOP_NONE;
      pow_r <= '0;
      err_r <= pee_pkg::ST_OK;
    end else begin
      go_r <= issue;
      if (emit) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            cur_r <= q_data;
            case (q_data.kind)
              pee_pkg::K_FIRST: begin
                pow_r <= q_data.opd;
                st_r <= S_DONE;
              end
              pee_pkg::K_POW: begin
                if (q_data.opd[VW-1]) begin
                  err_r <= pee_pkg::ST_NEXP;
                  pow_r <= '0;
                  st_r <= S_DONE;
                end else begin
                  a_op <= A_POW;
                  a_a <= pow_r;
                  a_b <= q_data.opd;
                  st_r <= S_POW;
                end
              end
              default: st_r <= S_CT;
            endcase
          end
        end
        S_POW: begin
          if (a_done) begin
            pow_r <= a_res;
            st_r <= S_DONE;
          end
        end
        S_CT: begin
          // close the pending term
          if (top_r == pee_pkg::TOP_NONE) begin
            ct_r <= pow_r;
            st_r <= S_WAIT;
          end else if (top_r != pee_pkg::TOP_MUL && pow_r == '0) begin
            if (err_r == pee_pkg::ST_OK) err_r <= pee_pkg::ST_DIV0;
            ct_r <= '0;
            st_r <= S_WAIT;
          end else begin
            a_op <= (top_r == pee_pkg::TOP_MUL) ? A_MUL :
                    (top_r == pee_pkg::TOP_DIV) ? A_DIV : A_MOD;
            a_a <= term_r;
            a_b <= pow_r;
            st_r <= S_MD;
          end
        end
        S_MD: begin
          if (a_done) begin
            ct_r <= a_res;
            st_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (cur_r.kind == pee_pkg::K_MD) begin
            term_r <= ct_r;
            top_r <= cur_r.mdop;
            pow_r <= cur_r.opd;
            st_r <= cur_r.last ? S_DONE : S_IDLE;
          end else if (cur_r.kind == pee_pkg::K_AS) begin
            sum_r <= sumc;
            sub_r <= cur_r.sub;
            term_r <= '0;
            top_r <= pee_pkg::TOP_NONE;
            pow_r <= cur_r.opd;
            st_r <= cur_r.last ? S_DONE : S_IDLE;
          end else if (emit) begin
            oval_r <= (err_r != pee_pkg::ST_OK) ? '0 : sumc;
            ost_r <= err_r;
            sum_r <= '0;
            sub_r <= 1'b0;
            term_r <= '0;
            top_r <= pee_pkg::TOP_NONE;
            pow_r <= '0;
            err_r <= pee_pkg::ST_OK;
            st_r <= S_IDLE;
          end
        end
        S_DONE: begin
          if (cur_r.last) st_r <= S_CT;
          else st_r <= S_IDLE;
          cur_r.kind <= pee_pkg::K_FIRST;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_tready) |=> ov_r) else $error("result dropped");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (ost_r == pee_pkg::ST_OK || ost_r == pee_pkg::ST_NEXP ||
              ost_r == pee_pkg::ST_DIV0)) else $error("bad status");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ost_r != pee_pkg::ST_OK) |-> oval_r == '0) else $error("value on error");

endmodule

// ----- sv/precedence_expression_evaluator.sv -----
// ----------------------------------------------------------------------------
// precedence_expression_evaluator
// streaming integer expression evaluator with operator precedence
// ----------------------------------------------------------------------------
// in channel: one transaction per operand; tdata the operand, tuser the
// operator joining it to the previous operand (ignored on the first), tlast
// marks the final operand. out channel: one transaction per expression,
// tdata the 64-bit wrapped value, tuser the status (0 ok, 1 negative
// exponent, 2 division by zero); value is zero when status is nonzero.
// a two-entry queue separates the classifying front from the evaluator.
// a multiply, divide or modulo closing a term runs 64 steps on the shared
// unit; a power runs, per exponent bit, an optional 64-step multiply and,
// while bits remain, a 64-step square. a last operand adds one more term
// close before the result is registered; items are taken one at a time.
// reset returns the state machines to idle, clears the sum, term, power
// and status registers and empties the queue; while out_tready is low the
// finished result is held and the evaluator goes on with the next
// expression until its result is ready, the queue still filling.
// ----------------------------------------------------------------------------
module precedence_expression_evaluator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // operand
  input  logic [2:0]  in_tuser,   // command
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // value
  output logic [1:0]  out_tuser   // status
);

  logic         q_valid, q_ready;
  pee_pkg::op_t q_data;

  pee_front u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tlast(in_tlast),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  pee_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
    .q_data(q_data), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

endmodule

// ----- sim/precedence_expression_evaluator_test.sv -----
// ----------------------------------------------------------------------------
// precedence_expression_evaluator_test
// self-checking testbench of the streaming expression evaluator
// ----------------------------------------------------------------------------
// a driver feeds operand transactions from a queue that the stimulus process
// fills: a directed set first (extreme operands, every operator, zero and
// negative exponents, zero divisors, both errors, the most negative value
// over minus one, the spare commands), then random expressions. every
// accepted operand goes through a local precedence evaluator, and each
// result transaction is compared with the oldest predicted value and status.
// the run covers three idle patterns on the two channels; a watchdog ends
// the run when nothing moves for too long.
// ----------------------------------------------------------------------------
module precedence_expression_evaluator_test;

  localparam int STALL_LIMIT = 60000;

  typedef struct packed {
    logic [63:0] opd;
    logic [2:0]  cmd;
    logic        last;
  } operand_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;

  operand_t pending_operands[$];
  result_t  expected_results[$];
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       fail_count = 0;
  int       quiet_cycles = 0;

  // evaluator state
  logic        ev_at_start = 1'b1;
  logic [63:0] ev_sum = '0;
  logic        ev_sub = 1'b0;
  logic [63:0] ev_term = '0;
  logic [1:0]  ev_top = pee_pkg::TOP_NONE;
  logic [63:0] ev_pow = '0;
  logic [1:0]  ev_err = pee_pkg::ST_OK;

  precedence_expression_evaluator u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void raise_error(logic [1:0] code);
    if (code == pee_pkg::ST_NEXP) ev_err = pee_pkg::ST_NEXP;
    else if (ev_err == pee_pkg::ST_OK) ev_err = code;
  endfunction

  function automatic logic [63:0] raise_power(logic [63:0] base, logic [63:0] e);
    logic [63:0] r;
    r = 64'd1;
    if (e[63]) begin
      raise_error(pee_pkg::ST_NEXP);
      return '0;
    end
    while (e != 0) begin
      if (e[0]) r = r * base;
      base = base * base;
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic logic [63:0] mul_div(logic [63:0] a, logic [63:0] b,
                                          logic [1:0] op);
    logic [63:0] ua, ub, q, r;
    if (op == pee_pkg::TOP_MUL) return a * b;
    if (b == 0) begin
      raise_error(pee_pkg::ST_DIV0);
      return '0;
    end
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    q = ua / ub;
    r = ua % ub;
    if (op == pee_pkg::TOP_DIV) return (a[63] != b[63]) ? -q : q;
    return a[63] ? -r : r;
  endfunction

  function automatic logic [63:0] close_term();
    if (ev_top == pee_pkg::TOP_NONE) return ev_pow;
    return mul_div(ev_term, ev_pow, ev_top);
  endfunction

  function automatic logic [63:0] close_sum();
    logic [63:0] t;
    t = close_term();
    return ev_sub ? ev_sum - t : ev_sum + t;
  endfunction

  function automatic void clear_evaluator();
    ev_at_start = 1'b1;
    ev_sum = '0;
    ev_sub = 1'b0;
    ev_term = '0;
    ev_top = pee_pkg::TOP_NONE;
    ev_pow = '0;
    ev_err = pee_pkg::ST_OK;
  endfunction

  function automatic void evaluate_operand(operand_t it);
    result_t res;
    logic [63:0] v;
    if (ev_at_start) begin
      clear_evaluator();
      ev_at_start = 1'b0;
      ev_pow = it.opd;
    end else if (it.cmd == pee_pkg::CMD_POW) begin
      ev_pow = raise_power(ev_pow, it.opd);
    end else if (it.cmd == pee_pkg::CMD_MUL || it.cmd == pee_pkg::CMD_DIV ||
                 it.cmd == pee_pkg::CMD_MOD) begin
      ev_term = close_term();
      ev_top = 2'(it.cmd - 3'd1);
      ev_pow = it.opd;
    end else begin
      ev_sum = close_sum();
      ev_sub = (it.cmd != pee_pkg::CMD_ADD);
      ev_term = '0;
      ev_top = pee_pkg::TOP_NONE;
      ev_pow = it.opd;
    end
    if (it.last) begin
      v = close_sum();
      res.value = (ev_err != pee_pkg::ST_OK) ? '0 : v;
      res.status = ev_err;
      expected_results.push_back(res);
      clear_evaluator();
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) evaluate_operand({in_tdata, in_tuser, in_tlast});
      if (!in_tvalid || in_tready) begin
        if (pending_operands.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          operand_t it;
          it = pending_operands.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= it.opd;
          in_tuser <= it.cmd;
          in_tlast <= it.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction value=%h status=%0d", out_tdata, out_tuser);
          fail_count++;
        end else begin
          result_t exp_res;
          exp_res = expected_results.pop_front();
          if (out_tdata !== exp_res.value) begin
            $error("value expected %h actual %h", exp_res.value, out_tdata);
            fail_count++;
          end
          if (out_tuser !== exp_res.status) begin
            $error("status expected %0d actual %0d", exp_res.status, out_tuser);
            fail_count++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_operand(logic [63:0] opd, logic [2:0] cmd, logic last);
    pending_operands.push_back({opd, cmd, last});
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_operand();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) return 64'($signed($urandom_range(40)) - 20);
    if (pick < 55) return {1'b1, 63'd0};
    if (pick < 60) return {1'b0, {63{1'b1}}};
    if (pick < 63) return 64'd0;
    return rand_word();
  endfunction

  function automatic logic [63:0] rand_exponent();
    int pick;
    pick = $urandom_range(99);
    if (pick < 78) return 64'($urandom_range(6));
    if (pick < 88) return -64'($urandom_range(1, 5));
    if (pick < 98) return 64'($urandom_range(7, 63));
    if (pick < 99) return rand_word() | {1'b1, 63'd0};
    return rand_word() & {1'b0, {63{1'b1}}};
  endfunction

  task automatic add_random_expressions(int count);
    int n, len;
    logic [2:0] cmd;
    n = 0;
    while (n < count) begin
      len = $urandom_range(1, 7);
      for (int i = 0; i < len; i++) begin
        cmd = 3'($urandom_range(7));
        if (i > 0 && cmd == pee_pkg::CMD_POW) add_operand(rand_exponent(), cmd, i == len - 1);
        else add_operand(rand_operand(), cmd, i == len - 1);
      end
      n += len;
    end
  endtask

  task automatic drain();
    wait (pending_operands.size() == 0 && expected_results.size() == 0 && !in_tvalid);
    repeat (300) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 12;
    recv_idle_pct = 70;

    // single operands at the extremes
    add_operand({1'b1, 63'd0}, pee_pkg::CMD_POW, 1'b1);
    add_operand({1'b0, {63{1'b1}}}, 3'd7, 1'b1);
    // 2 + 3 * 4 - 10 / 3 % 2
    add_operand(64'd2, pee_pkg::CMD_ADD, 1'b0);
    add_operand(64'd3, pee_pkg::CMD_ADD, 1'b0);
    add_operand(64'd4, pee_pkg::CMD_MUL, 1'b0);
    add_operand(64'd10, pee_pkg::CMD_SUB, 1'b0);
    add_operand(64'd3, pee_pkg::CMD_DIV, 1'b0);
    add_operand(64'd2, pee_pkg::CMD_MOD, 1'b1);
    // power left to right, zero exponent with base zero
    add_operand(64'd2, pee_pkg::CMD_ADD, 1'b0);
    add_operand(64'd3, pee_pkg::CMD_POW, 1'b0);
    add_operand(64'd2, pee_pkg::CMD_POW, 1'b0);
    add_operand(64'd0, pee_pkg::CMD_ADD, 1'b0);
    add_operand(64'd0, pee_pkg::CMD_POW, 1'b1);
    // zero divisor then negative exponent: negative exponent wins
    add_operand(64'd5, pee_pkg::CMD_ADD, 1'b0);
    add_operand(64'd0, pee_pkg::CMD_DIV, 1'b0);
    add_operand(-64'd1, pee_pkg::CMD_ADD, 1'b0);
    add_operand(-64'd2, pee_pkg::CMD_POW, 1'b1);
    // modulo by zero
    add_operand(64'd7, pee_pkg::CMD_ADD, 1'b0);
    add_operand(64'd0, pee_pkg::CMD_MOD, 1'b1);
    // most negative over minus one, modulo minus one, spare command
    add_operand({1'b1, 63'd0}, pee_pkg::CMD_ADD, 1'b0);
    add_operand(-64'd1, pee_pkg::CMD_DIV, 1'b0);
    add_operand({1'b1, 63'd0}, 3'd6, 1'b0);
    add_operand(-64'd1, pee_pkg::CMD_MOD, 1'b1);
    // long exponent
    add_operand(64'd3, pee_pkg::CMD_ADD, 1'b0);
    add_operand({1'b0, {63{1'b1}}}, pee_pkg::CMD_POW, 1'b1);
    add_random_expressions(160);
    drain();

    send_idle_pct = 70;
    recv_idle_pct = 12;
    add_random_expressions(170);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_expressions(170);
    drain();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/pee_pkg.sv
sv/pee_front.sv
sv/pee_alu.sv
sv/pee_back.sv
sv/precedence_expression_evaluator.sv
sim/precedence_expression_evaluator_test.sv
